[rtl/saq_pkg.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// saq_pkg
// Shared types and constants of the sorted array priority queue.
// -----------------------------------------------------------------------------
package saq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF   = 16;
  localparam int unsigned PRIORITY_BITS_DEF = 16;
  localparam int unsigned COUNT_W_DEF       = $clog2(QUEUE_DEPTH_DEF + 1);

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned PRIO_IN_W = 16;

  localparam logic [DATA_W-1:0] NO_DATA = {DATA_W{1'b1}};

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // control from the request side to the sequencer
  typedef struct packed {
    logic start;
    logic ack;
  } seq_ctl_t;

  // finished result held by the sequencer
  typedef struct packed {
    logic              valid;
    status_e           status;
    logic [DATA_W-1:0] data;
  } seq_rsp_t;

endpackage

[rtl/saq_req_if.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// saq_req_if
// Request channel: operation, data and priority with valid/ready.
// -----------------------------------------------------------------------------
interface saq_req_if
  import saq_pkg::*;
();
  logic                 valid;
  logic                 ready;
  op_e                  operation;
  logic [DATA_W-1:0]    data_value;
  logic [PRIO_IN_W-1:0] priority_req;

  modport source (output valid, operation, data_value, priority_req, input ready);
  modport sink   (input valid, operation, data_value, priority_req, output ready);
endinterface

[rtl/saq_rsp_if.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// saq_rsp_if
// Result channel: status, removed data, count and flags with valid/ready.
// -----------------------------------------------------------------------------
interface saq_rsp_if
  import saq_pkg::*;
#(
  parameter int unsigned COUNT_W = COUNT_W_DEF
) ();
  logic               valid;
  logic               ready;
  status_e            status;
  logic [DATA_W-1:0]  head_data;
  logic [COUNT_W-1:0] count;
  logic               is_empty;
  logic               is_full;

  modport source (output valid, status, head_data, count, is_empty, is_full, input ready);
  modport sink   (input valid, status, head_data, count, is_empty, is_full, output ready);
endinterface

[rtl/sorted_array_priority_queue_unit.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// sorted_array_priority_queue_unit
// Bounded priority queue kept sorted in a memory, lower priority value first.
// -----------------------------------------------------------------------------
// Usage:
//   req_i carries one request: an enqueue (data_value, priority_req) or a
//   dequeue. rsp_o returns one result per request: status, removed data,
//   count after the operation and the empty and full flags.
//   Entries of equal priority leave in arrival order.
// Flow:
//   One request is worked on at a time. An enqueue moves every entry with a
//   higher priority value one place toward the tail, a dequeue moves the
//   rest one place toward the head, a rejected enqueue or an empty dequeue
//   moves none. The single memory read and write port moves one entry per cycle.
//   req_i.ready is low while a request is worked on; the next request is
//   taken as soon as the result sits in the output register.
// Reset:
//   rst_ni clears the count, the queue is empty. The memory is not cleared.
// Stall:
//   A result held by a low rsp_o.ready stays stable; one more request may
//   complete behind it, then req_i.ready stays low until it drains.
// -----------------------------------------------------------------------------
module sorted_array_priority_queue_unit
  import saq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
  parameter int unsigned PRIORITY_BITS = PRIORITY_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  saq_req_if.sink   req_i,
  saq_rsp_if.source rsp_o
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic                     busy_q;
  logic                     start_q;
  op_e                      op_q;
  logic [DATA_W-1:0]        data_q;
  logic [PRIORITY_BITS-1:0] prio_q;
  logic [31:0]              prio_ext;
  logic                     req_acc;

  seq_ctl_t                 ctl;
  seq_rsp_t                 seq_rsp;
  logic [CW-1:0]            seq_count;

  logic                     we;
  logic [AW-1:0]            waddr;
  logic [DATA_W-1:0]        wdata;
  logic [PRIORITY_BITS-1:0] wprio;
  logic                     re;
  logic [AW-1:0]            raddr;
  logic [DATA_W-1:0]        rdata;
  logic [PRIORITY_BITS-1:0] rprio;

  logic                     out_valid_q;
  status_e                  out_status_q;
  logic [DATA_W-1:0]        out_data_q;
  logic [CW-1:0]            out_count_q;

  assign req_i.ready = !busy_q;
  assign req_acc     = req_i.valid && !busy_q;
  assign prio_ext    = 32'(req_i.priority_req);

  assign ctl.start = start_q;
  assign ctl.ack   = seq_rsp.valid && (!out_valid_q || rsp_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      start_q <= req_acc;
      if (req_acc) begin
        busy_q <= 1'b1;
      end else if (ctl.ack) begin
        busy_q <= 1'b0;
      end
      if (ctl.ack) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      op_q   <= req_i.operation;
      data_q <= req_i.data_value;
      prio_q <= prio_ext[PRIORITY_BITS-1:0];
    end
    if (ctl.ack) begin
      out_status_q <= seq_rsp.status;
      out_data_q   <= seq_rsp.data;
      out_count_q  <= seq_count;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.status    = out_status_q;
  assign rsp_o.head_data = out_data_q;
  assign rsp_o.count     = out_count_q;
  assign rsp_o.is_empty  = (out_count_q == '0);
  assign rsp_o.is_full   = (out_count_q == CW'(QUEUE_DEPTH));

  saq_seq #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (ctl),
    .op_i    (op_q),
    .data_i  (data_q),
    .prio_i  (prio_q),
    .rsp_o   (seq_rsp),
    .count_o (seq_count),
    .we_o    (we),
    .waddr_o (waddr),
    .wdata_o (wdata),
    .wprio_o (wprio),
    .re_o    (re),
    .raddr_o (raddr),
    .rdata_i (rdata),
    .rprio_i (rprio)
  );

  saq_store #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .wprio_i (wprio),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata),
    .rprio_o (rprio)
  );

endmodule

[rtl/saq_store.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// saq_store
// Entry memory: one write port, one read port with registered read data.
// -----------------------------------------------------------------------------
module saq_store
  import saq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
  parameter int unsigned PRIORITY_BITS = PRIORITY_BITS_DEF,
  localparam int unsigned AW           = $clog2(QUEUE_DEPTH)
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AW-1:0]            waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic [PRIORITY_BITS-1:0] wprio_i,
  input  logic                     re_i,
  input  logic [AW-1:0]            raddr_i,
  output logic [DATA_W-1:0]        rdata_o,
  output logic [PRIORITY_BITS-1:0] rprio_o
);

  logic [DATA_W-1:0]        data_mem [QUEUE_DEPTH];
  logic [PRIORITY_BITS-1:0] prio_mem [QUEUE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      data_mem[waddr_i] <= wdata_i;
      prio_mem[waddr_i] <= wprio_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= data_mem[raddr_i];
      rprio_o <= prio_mem[raddr_i];
    end
  end

endmodule

[rtl/saq_seq.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// saq_seq
// Sequencer: shifts entries one per cycle through the single compare unit
// for an insert, or one per cycle toward the head for a removal.
// -----------------------------------------------------------------------------
module saq_seq
  import saq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH   = QUEUE_DEPTH_DEF,
  parameter int unsigned PRIORITY_BITS = PRIORITY_BITS_DEF,
  localparam int unsigned AW           = $clog2(QUEUE_DEPTH),
  localparam int unsigned CW           = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  seq_ctl_t                 ctl_i,
  input  op_e                      op_i,
  input  logic [DATA_W-1:0]        data_i,
  input  logic [PRIORITY_BITS-1:0] prio_i,
  output seq_rsp_t                 rsp_o,
  output logic [CW-1:0]            count_o,
  output logic                     we_o,
  output logic [AW-1:0]            waddr_o,
  output logic [DATA_W-1:0]        wdata_o,
  output logic [PRIORITY_BITS-1:0] wprio_o,
  output logic                     re_o,
  output logic [AW-1:0]            raddr_o,
  input  logic [DATA_W-1:0]        rdata_i,
  input  logic [PRIORITY_BITS-1:0] rprio_i
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_CMP,
    S_INS_WR,
    S_DEQ_HEAD,
    S_DEQ_SHIFT,
    S_DONE
  } state_e;

  state_e            state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [AW-1:0]     pos_q, pos_d;
  status_e           status_q, status_d;
  logic [DATA_W-1:0] data_q, data_d;

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    pos_d    = pos_q;
    status_d = status_q;
    data_d   = data_q;
    we_o     = 1'b0;
    waddr_o  = pos_q;
    wdata_o  = data_i;
    wprio_o  = prio_i;
    re_o     = 1'b0;
    raddr_o  = pos_q;

    unique case (state_q)
      S_IDLE: begin
        if (ctl_i.start) begin
          if (op_i == OP_ENQ) begin
            if (count_q == CW'(QUEUE_DEPTH)) begin
              status_d = ST_FULL;
              data_d   = '0;
              state_d  = S_DONE;
            end else if (count_q == '0) begin
              pos_d   = '0;
              state_d = S_INS_WR;
            end else begin
              re_o    = 1'b1;
              raddr_o = AW'(count_q - CW'(1));
              pos_d   = AW'(count_q);
              state_d = S_INS_CMP;
            end
          end else begin
            if (count_q == '0) begin
              status_d = ST_EMPTY;
              data_d   = NO_DATA;
              state_d  = S_DONE;
            end else begin
              re_o    = 1'b1;
              raddr_o = '0;
              state_d = S_DEQ_HEAD;
            end
          end
        end
      end
      // read data holds entry pos-1; move it up while the new priority is lower
      S_INS_CMP: begin
        if (prio_i < rprio_i) begin
          we_o    = 1'b1;
          wdata_o = rdata_i;
          wprio_o = rprio_i;
          pos_d   = pos_q - AW'(1);
          if (pos_q == AW'(1)) begin
            state_d = S_INS_WR;
          end else begin
            re_o    = 1'b1;
            raddr_o = pos_q - AW'(2);
          end
        end else begin
          we_o     = 1'b1;
          count_d  = count_q + CW'(1);
          status_d = ST_DONE;
          data_d   = '0;
          state_d  = S_DONE;
        end
      end
      S_INS_WR: begin
        we_o     = 1'b1;
        count_d  = count_q + CW'(1);
        status_d = ST_DONE;
        data_d   = '0;
        state_d  = S_DONE;
      end
      S_DEQ_HEAD: begin
        data_d   = rdata_i;
        status_d = ST_DONE;
        if (count_q == CW'(1)) begin
          count_d = '0;
          state_d = S_DONE;
        end else begin
          re_o    = 1'b1;
          raddr_o = AW'(1);
          pos_d   = '0;
          state_d = S_DEQ_SHIFT;
        end
      end
      // read data holds entry pos+1, written one place toward the head
      S_DEQ_SHIFT: begin
        we_o    = 1'b1;
        wdata_o = rdata_i;
        wprio_o = rprio_i;
        if ((CW'(pos_q) + CW'(1)) == (count_q - CW'(1))) begin
          count_d = count_q - CW'(1);
          state_d = S_DONE;
        end else begin
          re_o    = 1'b1;
          raddr_o = pos_q + AW'(2);
          pos_d   = pos_q + AW'(1);
        end
      end
      S_DONE: begin
        if (ctl_i.ack) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      pos_q    <= '0;
      status_q <= ST_DONE;
      data_q   <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      pos_q    <= pos_d;
      status_q <= status_d;
      data_q   <= data_d;
    end
  end

  assign rsp_o.valid  = (state_q == S_DONE);
  assign rsp_o.status = status_q;
  assign rsp_o.data   = data_q;
  assign count_o      = count_q;

endmodule

[rtl/saq_checker.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// saq_checker
// Port-level checks of the priority queue results.
// -----------------------------------------------------------------------------
module saq_checker
  import saq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  localparam int unsigned CW         = $clog2(QUEUE_DEPTH + 1)
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              rsp_valid_i,
  input logic              rsp_ready_i,
  input status_e           rsp_status_i,
  input logic [DATA_W-1:0] rsp_data_i,
  input logic [CW-1:0]     rsp_count_i,
  input logic              rsp_empty_i,
  input logic              rsp_full_i
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_data_i)
      && $stable(rsp_count_i))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (rsp_empty_i == (rsp_count_i == '0))
      && (rsp_full_i == (rsp_count_i == CW'(QUEUE_DEPTH))))
    else $error("flags disagree with count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i == ST_EMPTY) |-> rsp_empty_i
      && (rsp_data_i == NO_DATA))
    else $error("empty dequeue result wrong");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i == ST_FULL) |-> rsp_full_i && (rsp_data_i == '0))
    else $error("rejected enqueue result wrong");

endmodule

bind sorted_array_priority_queue_unit saq_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_saq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_data_i   (rsp_o.head_data),
  .rsp_count_i  (rsp_o.count),
  .rsp_empty_i  (rsp_o.is_empty),
  .rsp_full_i   (rsp_o.is_full)
);
